>>> design/nltp_pkg.sv
// ---------------------------------------------------------------------------
// nltp_pkg: shared types and constants for the numeric literal token parser
// Phase encoding, result record, character codes and output shaping helpers.
// ---------------------------------------------------------------------------
package nltp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int BITS_W      = 6;
  localparam int MAX_RESULTS = 2;
  localparam int RES_DEPTH   = 4;
  localparam int RES_AW      = 2;
  localparam int RES_CW      = 3;

  localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
  localparam logic [7:0] CH_ONE       = 8'h31;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LC_X      = 8'h78;
  localparam logic [7:0] CH_UC_X      = 8'h58;
  localparam logic [7:0] CH_LC_B      = 8'h62;
  localparam logic [7:0] CH_UC_B      = 8'h42;
  localparam logic [7:0] CH_LC_A      = 8'h61;
  localparam logic [7:0] CH_LC_F      = 8'h66;
  localparam logic [7:0] CH_UC_A      = 8'h41;
  localparam logic [7:0] CH_UC_F      = 8'h46;
  localparam logic [7:0] CH_CASE_BIT  = 8'h20;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;

  localparam logic [BITS_W-1:0]    BITS_RESET = 6'd8;
  localparam logic [BITS_W-1:0]    BITS_MAX   = BITS_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] REP_RESET  = WORD_BITS'(1);

  // field of the token being parsed
  localparam logic [1:0] FLD_VALUE  = 2'd0;
  localparam logic [1:0] FLD_BITS   = 2'd1;
  localparam logic [1:0] FLD_REPEAT = 2'd2;

  typedef enum logic [5:0] {
    SUB_IDLE  = 6'b000001,
    SUB_START = 6'b000010,
    SUB_ZERO  = 6'b000100,
    SUB_DEC   = 6'b001000,
    SUB_HEX   = 6'b010000,
    SUB_BIN   = 6'b100000
  } sub_t;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    sub_t                  sub;
    logic [1:0]            field;
    logic [WORD_BITS-1:0]  acc;
    logic [WORD_BITS-1:0]  tok;
    logic [BITS_W-1:0]     bits;
    logic [WORD_BITS-1:0]  rep;
    logic                  skip;
  } state_t;

  // value is held unmasked; masking and bit order are applied at the output
  typedef struct packed {
    kind_t                 kind;
    logic [WORD_BITS-1:0]  value;
    logic [BITS_W-1:0]     bits;
    logic [WORD_BITS-1:0]  rep;
    logic [7:0]            ch;
    logic                  last;
  } result_t;

  function automatic logic [WORD_BITS-1:0] mask_value(logic [WORD_BITS-1:0] v,
                                                      logic [BITS_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= BITS_MAX) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n[BITS_W-2:0]) - WORD_BITS'(1);
    end
    return v & m;
  endfunction

  // reverse the low n bits of v (v already masked to n bits)
  function automatic logic [WORD_BITS-1:0] reverse_low(logic [WORD_BITS-1:0] v,
                                                       logic [BITS_W-1:0] n);
    logic [WORD_BITS-1:0] r;
    logic [BITS_W-1:0]    sh;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[WORD_BITS-1-i] = v[i];
    end
    sh = BITS_MAX - n;
    return r >> sh[BITS_W-2:0];
  endfunction

endpackage

>>> design/nltp_step.sv
// ---------------------------------------------------------------------------
// nltp_step: next-state and result logic for one character
// Advances the parse phase and produces up to two result records.
// ---------------------------------------------------------------------------
module nltp_step (
  input  nltp_pkg::state_t                st,
  input  logic [7:0]                      char_code,
  input  logic                            end_of_line,
  output nltp_pkg::state_t                st_next,
  output nltp_pkg::result_t [1:0]         res,
  output logic [1:0]                      res_n
);
  import nltp_pkg::*;

  // closes the current field; returns 0 when the bit count is out of range
  function automatic logic commit_fld(inout state_t s);
    logic [WORD_BITS-1:0] a;
    logic                 ok;
    a     = s.acc;
    s.acc = '0;
    ok    = 1'b1;
    unique case (s.field)
      FLD_VALUE: s.tok = a;
      FLD_BITS: begin
        if (a > WORD_BITS'(WORD_BITS)) begin
          ok = 1'b0;
        end else if (a != '0) begin
          s.bits = a[BITS_W-1:0];
        end
      end
      default: s.rep = a;
    endcase
    return ok;
  endfunction

  function automatic void clear_tok(inout state_t s);
    s.sub   = SUB_IDLE;
    s.field = FLD_VALUE;
    s.acc   = '0;
    s.tok   = '0;
    s.rep   = REP_RESET;
  endfunction

  state_t              s;
  result_t             r [2];
  logic [1:0]          n;
  logic                is_digit;
  logic                is_hex;
  logic [3:0]          d;
  logic [3:0]          nib;
  logic [7:0]          lc;
  logic                fall;
  logic                err;
  logic                ended;
  logic                from_idle;
  logic                ok;
  result_t             r_tok;
  result_t             r_err;
  result_t             r_chr;

  always_comb begin
    s         = st;
    r[0]      = '0;
    r[1]      = '0;
    n         = 2'd0;
    fall      = 1'b0;
    err       = 1'b0;
    ended     = 1'b0;
    from_idle = 1'b0;
    ok        = 1'b1;
    r_tok     = '0;
    r_err     = '0;
    r_chr     = '0;
    is_digit  = (char_code >= CH_DIGIT_LO) && (char_code <= CH_DIGIT_HI);
    d         = 4'(char_code - CH_DIGIT_LO);
    lc        = char_code | CH_CASE_BIT;
    is_hex    = is_digit || ((char_code >= CH_LC_A) && (char_code <= CH_LC_F)) ||
                ((char_code >= CH_UC_A) && (char_code <= CH_UC_F));
    nib       = is_digit ? d : 4'(lc - HEX_ALPHA_OFS);

    if (s.skip) begin
      if (end_of_line) s.skip = 1'b0;
    end else begin
      if (s.sub != SUB_IDLE) begin
        unique case (s.sub)
          SUB_START: begin
            if (!is_digit) begin
              err = 1'b1;
            end else begin
              s.acc = WORD_BITS'(d);
              s.sub = (d == 4'd0) ? SUB_ZERO : SUB_DEC;
            end
          end
          SUB_ZERO: begin
            if (is_digit) begin
              s.acc = WORD_BITS'(d);
              s.sub = SUB_DEC;
            end else if (char_code == CH_LC_X || char_code == CH_UC_X) begin
              s.sub = SUB_HEX;
            end else if (char_code == CH_LC_B || char_code == CH_UC_B) begin
              s.sub = SUB_BIN;
            end else begin
              fall = 1'b1;
            end
          end
          SUB_DEC: begin
            if (is_digit) s.acc = (s.acc << 3) + (s.acc << 1) + WORD_BITS'(d);
            else fall = 1'b1;
          end
          SUB_HEX: begin
            if (is_hex) s.acc = {s.acc[WORD_BITS-5:0], nib};
            else fall = 1'b1;
          end
          SUB_BIN: begin
            if (char_code == CH_DIGIT_LO || char_code == CH_ONE) begin
              s.acc = {s.acc[WORD_BITS-2:0], char_code[0]};
            end else begin
              fall = 1'b1;
            end
          end
          default: ;
        endcase

        if (fall) begin
          ok = commit_fld(s);
          if (!ok) begin
            err = 1'b1;
          end else if (s.field == FLD_VALUE && char_code == CH_DOT) begin
            s.field = FLD_BITS;
            s.sub   = SUB_START;
          end else if (s.field != FLD_REPEAT && char_code == CH_COLON) begin
            s.field = FLD_REPEAT;
            s.sub   = SUB_START;
          end else begin
            ended = 1'b1;
          end
        end

        if (err) begin
          r_err.kind = KIND_ERROR;
          r_err.bits = s.bits;
          r[n[0]]    = r_err;
          n          = n + 2'd1;
          clear_tok(s);
          s.skip = !end_of_line;
        end else if (ended) begin
          r_tok.kind  = KIND_VALUE;
          r_tok.value = s.tok;
          r_tok.bits  = s.bits;
          r_tok.rep   = s.rep;
          r[n[0]]     = r_tok;
          n           = n + 2'd1;
          clear_tok(s);
          from_idle = 1'b1;
        end
      end else begin
        from_idle = 1'b1;
      end

      // character seen outside a token, or the one that ended a token
      if (from_idle) begin
        if (is_digit) begin
          clear_tok(s);
          s.acc = WORD_BITS'(d);
          s.sub = (d == 4'd0) ? SUB_ZERO : SUB_DEC;
        end else begin
          r_chr.kind = KIND_CHAR;
          r_chr.bits = s.bits;
          r_chr.ch   = char_code;
          r[n[0]]    = r_chr;
          n          = n + 2'd1;
        end
      end

      // line ends with a token still open
      if (end_of_line && s.sub != SUB_IDLE) begin
        if (s.sub == SUB_START) ok = 1'b0;
        else ok = commit_fld(s);
        r_tok = '0;
        r_err = '0;
        if (ok) begin
          r_tok.kind  = KIND_VALUE;
          r_tok.value = s.tok;
          r_tok.bits  = s.bits;
          r_tok.rep   = s.rep;
          r[n[0]]     = r_tok;
        end else begin
          r_err.kind = KIND_ERROR;
          r_err.bits = s.bits;
          r[n[0]]    = r_err;
        end
        n = n + 2'd1;
        clear_tok(s);
      end
      if (end_of_line) s.skip = 1'b0;
    end

    if (n == 2'd1) r[0].last = 1'b1;
    if (n == 2'd2) r[1].last = 1'b1;
  end

  assign st_next = s;
  assign res[0]  = r[0];
  assign res[1]  = r[1];
  assign res_n   = n;

endmodule

>>> design/nltp_res_fifo.sv
// ---------------------------------------------------------------------------
// nltp_res_fifo: result queue
// Small register queue taking up to two records per cycle, one out per cycle.
// ---------------------------------------------------------------------------
module nltp_res_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          push_n,
  input  nltp_pkg::result_t [1:0]             din,
  input  logic                                pop,
  output nltp_pkg::result_t                   head,
  output logic [nltp_pkg::RES_CW-1:0]         count
);
  import nltp_pkg::*;

  result_t            mem [RES_DEPTH];
  logic [RES_AW-1:0]  wr_ptr;
  logic [RES_AW-1:0]  rd_ptr;
  logic [RES_AW-1:0]  wr_ptr_p1;
  logic               do_pop;

  assign wr_ptr_p1 = wr_ptr + RES_AW'(1);
  assign do_pop    = pop && (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= din[0];
    if (push_n == 2'd2) mem[wr_ptr_p1] <= din[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_AW'(push_n);
      if (do_pop) rd_ptr <= rd_ptr + RES_AW'(1);
      count <= count + RES_CW'(push_n) - RES_CW'(do_pop);
    end
  end

endmodule

>>> design/numeric_literal_token_parser_unit.sv
// ---------------------------------------------------------------------------
// numeric_literal_token_parser_unit: command-line numeric literal parser
// Parses decimal, 0x and 0b literals with optional .bits and :repeat suffixes.
// ---------------------------------------------------------------------------
//  channel   dir   tdata                          tuser   tlast
//  s_axis    in    char_code[7:0]                 -       end_of_line
//  m_axis    out   value,tx_word,bit_count,       kind    last
//                  repeat_count,passed_char
//  cfg_wr    in    lsb_first (write enable + data, no read-back)
//
//  One character per cycle enters the input register while no stall holds
//  it; the combinational step logic then works on it and queues up to two
//  transfers, registered in the result queue ahead of m_axis.
//  The input register steps its character only while the result queue has
//  room for two records; a character giving two results leaves as two
//  transfers on m_axis. Reset (rst, synchronous): no open token, bit count
//  8, repeat 1, MSB first. Output stalls stop the input once the four-entry
//  queue holds three or more records.
// ---------------------------------------------------------------------------
module numeric_literal_token_parser_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] value, [63:32] tx_word, [69:64] bit_count, [101:70] repeat_count,
  // [109:102] passed_char, [111:110] zero
  output logic [111:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // [1:0] kind
  output logic          m_axis_tlast,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);
  import nltp_pkg::*;

  logic                  lsb_first;
  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_eol;
  logic                  step_go;
  state_t                st;
  state_t                st_next;
  result_t [1:0]         res;
  logic [1:0]            res_n;
  logic [1:0]            push_n;
  result_t               head;
  logic [RES_CW-1:0]     res_count;
  logic [WORD_BITS-1:0]  out_value;
  logic [WORD_BITS-1:0]  out_tx;

  assign step_go       = in_valid && (res_count <= RES_CW'(RES_DEPTH - MAX_RESULTS));
  assign s_axis_tready = !in_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first <= 1'b0;
    end else if (cfg_wr_en) begin
      lsb_first <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_eol  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.sub   <= SUB_IDLE;
      st.field <= FLD_VALUE;
      st.acc   <= '0;
      st.tok   <= '0;
      st.bits  <= BITS_RESET;
      st.rep   <= REP_RESET;
      st.skip  <= 1'b0;
    end else if (step_go) begin
      st <= st_next;
    end
  end

  nltp_step u_step (
    .st          (st),
    .char_code   (in_char),
    .end_of_line (in_eol),
    .st_next     (st_next),
    .res         (res),
    .res_n       (res_n)
  );

  assign push_n = step_go ? res_n : 2'd0;

  nltp_res_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .din    (res),
    .pop    (m_axis_tready),
    .head   (head),
    .count  (res_count)
  );

  // masking and bit order applied on the way out
  assign out_value = mask_value(head.value, head.bits);
  assign out_tx    = lsb_first ? reverse_low(out_value, head.bits) : out_value;

  assign m_axis_tvalid = (res_count != '0);
  assign m_axis_tdata  = {2'b00, head.ch, head.rep, head.bits, out_tx, out_value};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

`ifndef ASSERT_OFF
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    (st.bits != '0) && (st.bits <= BITS_MAX))
    else $error("stored bit count out of range");

  a_skip_idle: assert property (@(posedge clk) disable iff (rst)
    st.skip |-> (st.sub == SUB_IDLE))
    else $error("line skip with a token open");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CW'(RES_DEPTH))
    else $error("result queue overflow");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (st.sub == SUB_IDLE) && (st.bits == BITS_RESET) && !st.skip && !in_valid)
    else $error("parser not idle after reset");
`endif

endmodule

>>> tb/sv/tb_numeric_literal_token_parser_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_numeric_literal_token_parser_unit: self-checking bench for the parser
// Streams command-line characters into the block and checks every result
// transfer against a cycle-free model of the token parser.
// ---------------------------------------------------------------------------
module tb_numeric_literal_token_parser_unit;
  import nltp_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS   = 180;

  typedef struct packed {
    logic [7:0] code;
    logic       eol;
  } char_item_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] tx_word;
    logic [5:0]  bits;
    logic [31:0] rep;
    logic [7:0]  ch;
    logic        last;
  } token_rec_t;

  typedef enum {CHAR_TAKEN, CHAR_ENDS_TOKEN, CHAR_BAD} char_fate_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata = 8'd0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          cfg_wr_en = 1'b0;
  logic          cfg_wr_data = 1'b0;

  char_item_t    char_backlog[$];
  token_rec_t    expected_tokens[$];
  char_item_t    drive_item;
  int            mismatch_count = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  int            ready_mode = 0;
  int            mode_left = 0;
  int            quiet_cycles = 0;

  // parser state as seen from outside
  sub_t          p_sub;
  logic [1:0]    p_field;
  logic [31:0]   p_acc;
  logic [31:0]   p_tok;
  logic [31:0]   p_rep;
  logic [5:0]    p_bits;
  logic          p_skip;
  logic          cfg_lsb;

  always #5 clk = ~clk;

  numeric_literal_token_parser_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] keep_low(logic [31:0] v, logic [5:0] n);
    if (n >= 6'd32) begin
      return v;
    end
    return v & ((32'd1 << n) - 32'd1);
  endfunction

  function automatic logic [31:0] flip_low(logic [31:0] v, logic [5:0] n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < n) r[n - 1 - i] = v[i];
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
  endfunction

  task automatic push_result(kind_t k, logic [31:0] v, logic [31:0] tx, logic [31:0] rep,
                             logic [7:0] c);
    expected_tokens.push_back('{k, v, tx, p_bits, rep, c, 1'b0});
  endtask

  task automatic clear_token();
    p_sub   = SUB_IDLE;
    p_field = FLD_VALUE;
    p_acc   = '0;
    p_tok   = '0;
    p_rep   = 32'd1;
  endtask

  function automatic logic commit_field();
    logic [31:0] a;
    a = p_acc;
    p_acc = '0;
    if (p_field == FLD_VALUE) begin
      p_tok = a;
    end else if (p_field == FLD_BITS) begin
      if (a > 32'd32) return 1'b0;
      if (a != 0) p_bits = a[5:0];
    end else begin
      p_rep = a;
    end
    return 1'b1;
  endfunction

  task automatic emit_token();
    logic [31:0] v;
    v = keep_low(p_tok, p_bits);
    push_result(KIND_VALUE, v, cfg_lsb ? flip_low(v, p_bits) : v, p_rep, 8'd0);
    clear_token();
  endtask

  task automatic emit_error();
    push_result(KIND_ERROR, '0, '0, '0, 8'd0);
    clear_token();
  endtask

  task automatic outside_token(logic [7:0] c);
    if (is_digit(c)) begin
      clear_token();
      p_acc = 32'(c - CH_DIGIT_LO);
      p_sub = (c == CH_DIGIT_LO) ? SUB_ZERO : SUB_DEC;
    end else begin
      push_result(KIND_CHAR, '0, '0, '0, c);
    end
  endtask

  function automatic char_fate_t absorb_char(logic [7:0] c);
    logic       dig;
    logic [7:0] d;
    logic [7:0] nib;
    dig = is_digit(c);
    d   = c - CH_DIGIT_LO;
    case (p_sub)
      SUB_START: begin
        if (!dig) return CHAR_BAD;
        p_acc = 32'(d);
        p_sub = (d == 0) ? SUB_ZERO : SUB_DEC;
        return CHAR_TAKEN;
      end
      SUB_ZERO: begin
        if (dig) begin
          p_acc = 32'(d);
          p_sub = SUB_DEC;
          return CHAR_TAKEN;
        end
        if (c == CH_LC_X || c == CH_UC_X) begin
          p_sub = SUB_HEX;
          return CHAR_TAKEN;
        end
        if (c == CH_LC_B || c == CH_UC_B) begin
          p_sub = SUB_BIN;
          return CHAR_TAKEN;
        end
      end
      SUB_DEC: begin
        if (dig) begin
          p_acc = p_acc * 32'd10 + 32'(d);
          return CHAR_TAKEN;
        end
      end
      SUB_HEX: begin
        if (dig || (c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
          nib = dig ? d : ((c | CH_CASE_BIT) - HEX_ALPHA_OFS);
          p_acc = {p_acc[27:0], nib[3:0]};
          return CHAR_TAKEN;
        end
      end
      default: begin
        if (c == CH_DIGIT_LO || c == CH_ONE) begin
          p_acc = {p_acc[30:0], c[0]};
          return CHAR_TAKEN;
        end
      end
    endcase
    if (!commit_field()) return CHAR_BAD;
    if (p_field == FLD_VALUE && c == CH_DOT) begin
      p_field = FLD_BITS;
      p_sub   = SUB_START;
      return CHAR_TAKEN;
    end
    if (p_field != FLD_REPEAT && c == CH_COLON) begin
      p_field = FLD_REPEAT;
      p_sub   = SUB_START;
      return CHAR_TAKEN;
    end
    return CHAR_ENDS_TOKEN;
  endfunction

  task automatic parse_char(logic [7:0] c, logic eol);
    int         prior_n;
    char_fate_t fate;
    prior_n = expected_tokens.size();
    if (p_skip) begin
      if (eol) p_skip = 1'b0;
      return;
    end
    if (p_sub != SUB_IDLE) begin
      fate = absorb_char(c);
      if (fate == CHAR_BAD) begin
        emit_error();
        p_skip = !eol;
      end else if (fate == CHAR_ENDS_TOKEN) begin
        emit_token();
        outside_token(c);
      end
    end else begin
      outside_token(c);
    end
    // a token still open at the line end closes in the same step
    if (eol && p_sub != SUB_IDLE) begin
      if (p_sub == SUB_START || !commit_field()) emit_error();
      else emit_token();
    end
    if (eol) p_skip = 1'b0;
    if (expected_tokens.size() > prior_n) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_char(logic [7:0] c);
    char_backlog.push_back('{c, 1'b0});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic end_line();
    if (char_backlog.size() > 0) char_backlog[char_backlog.size() - 1].eol = 1'b1;
  endtask

  task automatic add_hex_digits(logic [31:0] v, int count, logic wide);
    string      s;
    logic [7:0] c;
    logic [3:0] nib;
    s = $sformatf("%0h", v);
    if (wide) begin
      for (int i = 0; i < count; i++) begin
        nib = 4'($urandom_range(0, 15));
        if (nib < 10) c = CH_DIGIT_LO + 8'(nib);
        else c = ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + 8'(nib) - 8'd10;
        add_char(c);
      end
    end else begin
      for (int i = 0; i < s.len(); i++) begin
        c = s[i];
        if (c >= CH_LC_A && c <= CH_LC_F && $urandom_range(0, 1)) c = c & ~CH_CASE_BIT;
        add_char(c);
      end
    end
  endtask

  task automatic add_number(logic [1:0] fld);
    logic [31:0] v;
    int          r;
    r = $urandom_range(0, 9);
    if (fld == FLD_VALUE) begin
      v = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 300);
    end else if (fld == FLD_BITS) begin
      if (r < 7) v = $urandom_range(1, 32);
      else if (r == 7) v = 0;
      else if (r == 8) v = $urandom_range(33, 80);
      else v = $urandom;
    end else begin
      v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if ($urandom_range(0, 4) == 0) add_char(CH_DIGIT_LO);
        add_text($sformatf("%0d", v));
      end
      4, 5: begin
        add_text($urandom_range(0, 1) ? "0x" : "0X");
        add_hex_digits(v, 0, 1'b0);
      end
      6: begin
        add_text($urandom_range(0, 1) ? "0b" : "0B");
        add_text($sformatf("%0b", v));
      end
      7: begin
        // long decimal, may wrap past the word width
        repeat ($urandom_range(10, 14)) add_char(CH_DIGIT_LO + 8'($urandom_range(0, 9)));
      end
      8: begin
        case ($urandom_range(0, 4))
          0: add_text("0");
          1: add_text("0x");
          2: add_text("0X");
          3: add_text("0b");
          default: add_text("0B");
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          add_text("0x");
          add_hex_digits(v, $urandom_range(9, 12), 1'b1);
        end else begin
          add_text("0b");
          repeat ($urandom_range(30, 40)) add_char(CH_DIGIT_LO + 8'($urandom_range(0, 1)));
        end
      end
    endcase
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    if ($urandom_range(0, 1)) return 8'h20;
    do c = 8'($urandom_range(32, 126)); while (is_digit(c));
    return c;
  endfunction

  task automatic add_good_line();
    int ntok;
    ntok = $urandom_range(1, 3);
    for (int t = 0; t < ntok; t++) begin
      add_number(FLD_VALUE);
      if ($urandom_range(0, 2) != 0) begin
        add_char(CH_DOT);
        add_number(FLD_BITS);
      end
      if ($urandom_range(0, 1)) begin
        add_char(CH_COLON);
        add_number(FLD_REPEAT);
      end
      if (t < ntok - 1 || $urandom_range(0, 2) == 0) add_char(pick_separator());
    end
    end_line();
  endtask

  task automatic add_broken_line();
    add_number(FLD_VALUE);
    add_char($urandom_range(0, 1) ? CH_DOT : CH_COLON);
    if ($urandom_range(0, 2) != 0) begin
      add_char(pick_separator());
      repeat ($urandom_range(0, 6)) add_char(8'($urandom_range(0, 255)));
    end
    end_line();
  endtask

  task automatic add_noise_line();
    string pool;
    pool = "..::xXbB0019aFg ";
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 1)) add_char(8'($urandom_range(0, 255)));
      else add_char(pool[$urandom_range(0, pool.len() - 1)]);
    end
    end_line();
  endtask

  task automatic fill_random_phase();
    int start;
    start = char_backlog.size();
    while (char_backlog.size() - start < PHASE_CHARS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: add_good_line();
        7: add_broken_line();
        default: add_noise_line();
      endcase
    end
  endtask

  task automatic fill_directed();
    add_text("0x.32"); end_line();   // empty prefix, full-width count
    add_text("0b12");  end_line();   // digit ends the binary token
    add_text("07:0");  end_line();   // leading zero stays decimal, zero repeat
    add_text("1.:5 x"); end_line();  // missing digits, rest of line skipped
    add_text("9.33");  end_line();   // count beyond the word
    add_char(8'h00);
    add_char(8'hFF);   end_line();
    add_text("1.");    end_line();   // line ends with digits missing
  endtask

  // ---------------------------------------------------------------- sequencing
  task automatic write_lsb_first(logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cfg_lsb = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds off until every result is back, then lets the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (char_backlog.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    p_bits  = BITS_RESET;
    p_skip  = 1'b0;
    cfg_lsb = 1'b0;
    clear_token();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_lsb_first(1'b0);
    fill_directed();
    drain();
    write_lsb_first(1'b1);
    fill_random_phase();
    drain();
    write_lsb_first(1'b0);
    fill_random_phase();
    drain();
    write_lsb_first(1'b1);
    fill_random_phase();
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (char_backlog.size() > 0) begin
          drive_item = char_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drive_item.code;
          s_axis_tlast  <= drive_item.eol;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic check_transfer();
    token_rec_t e;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", m_axis_tuser));
      return;
    end
    e = expected_tokens.pop_front();
    check_field("kind",         32'(m_axis_tuser),          32'(e.kind));
    check_field("value",        m_axis_tdata[31:0],         e.value);
    check_field("tx_word",      m_axis_tdata[63:32],        e.tx_word);
    check_field("bit_count",    32'(m_axis_tdata[69:64]),   32'(e.bits));
    check_field("repeat_count", m_axis_tdata[101:70],       e.rep);
    check_field("passed_char",  32'(m_axis_tdata[109:102]), 32'(e.ch));
    check_field("last",         32'(m_axis_tlast),          32'(e.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_transfer();
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 64);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (mode_left[2:0] == 3'd0);
      endcase
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
